[hdl/sequence_reorder_buffer_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sequence reorder buffer
// Concurrent checks compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_TOP_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_TOP_MACROS_SVH
`ifndef SYNTH
`define SRB_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRB_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define SRB_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SRB_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

[hdl/srb_pkg.sv]
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the sequence reorder buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package srb_pkg;
   localparam int RING_DEPTH   = 256;
   localparam int HANDLE_WIDTH = 32;
   localparam int IDX_W        = $clog2(RING_DEPTH);
   localparam int SEQ_W        = 64;
   localparam int TIME_W       = 48;
   localparam int DELAY_W      = 32;
   localparam int HOUT_W       = 32;
   localparam int ENTRY_W      = SEQ_W + TIME_W + HANDLE_WIDTH;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd1000000;

   typedef enum logic [2:0] {
      ST_STORED    = 3'd0,
      ST_LATE      = 3'd1,
      ST_DUP       = 3'd2,
      ST_BUSY      = 3'd3,
      ST_DELIVERED = 3'd4,
      ST_NOTHING   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_CHK,
      S_DEQ_CHK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0]        seq;
      logic [TIME_W-1:0]       tstamp;
      logic [HANDLE_WIDTH-1:0] handle;
   } entry_type;
endpackage

[hdl/srb_ram.sv]
// ----------------------------------------------------------------------------
// srb_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module srb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

[hdl/sequence_reorder_buffer_top.sv]
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_top
// Reorder ring: one slot RAM plus flip-flop valid bits.
// Enqueue and in-order dequeue: S_ENQ_CHK or S_DEQ_CHK, then S_DONE, then rsp_valid; busy meanwhile.
// Gap-skipping dequeue: scans the slots after the expected one, one slot per
// read/check pair, as the single RAM read port walks the ring.
// Synchronous reset clears valid bits and pointers at once; no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sequence_reorder_buffer_top_macros.svh"
module sequence_reorder_buffer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [srb_pkg::SEQ_W-1:0]         req_counter,
   input  logic [31:0]                       req_handle_in,
   input  logic [srb_pkg::TIME_W-1:0]        req_now,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic [srb_pkg::HOUT_W-1:0]        rsp_handle_out,
   output logic [srb_pkg::SEQ_W-1:0]         rsp_seq_out,
   output logic                              rsp_gap_skipped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srb_pkg::DELAY_W-1:0]       csr_data
);
   localparam int IW = srb_pkg::IDX_W;
   localparam int SW = srb_pkg::SEQ_W;
   localparam int TW = srb_pkg::TIME_W;

   srb_pkg::state_type state_ff, state_in;
   logic [srb_pkg::RING_DEPTH-1:0] full_ff, full_in;
   logic [SW-1:0] exp_ff, exp_in, high_ff, high_in, off_ff, off_in;
   logic [TW-1:0] last_ff, last_in;
   logic [srb_pkg::DELAY_W-1:0] delay_ff;
   logic cmd_ff;
   logic [SW-1:0] seq_ff, seq_in;
   logic [srb_pkg::HANDLE_WIDTH-1:0] hin_ff;
   logic [TW-1:0] now_ff;
   logic [IW:0] k_ff, k_in;
   logic [SW-1:0] cand_ff, cand_in;
   logic [2:0] st_ff, st_in;
   logic [srb_pkg::HOUT_W-1:0] ho_ff, ho_in;
   logic [SW-1:0] so_ff, so_in;
   logic gap_ff, gap_in;
   logic vld_ff, vld_in;

   logic ram_we;
   logic [IW-1:0] ram_addr;
   srb_pkg::entry_type ram_wd, ram_rd;

   srb_ram #(.WIDTH(srb_pkg::ENTRY_W), .DEPTH(srb_pkg::RING_DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
   );

   logic accept;
   logic [SW-1:0] req_off, req_seq;
   logic [TW:0] slot_exp, last_exp;
   logic slot_fresh, last_wait;
   logic [IW-1:0] exp_idx, cand_idx, seq_idx;

   assign accept    = start && !busy;
   assign busy      = (state_ff != srb_pkg::S_IDLE);
   assign csr_ready = (state_ff == srb_pkg::S_IDLE);
   assign req_off   = (req_counter == '0 && high_ff != '0) ? high_ff + 1'b1 : off_ff;
   assign req_seq   = req_counter + req_off;
   assign exp_idx   = exp_ff[IW-1:0];
   assign cand_idx  = cand_ff[IW-1:0];
   assign seq_idx   = seq_ff[IW-1:0];
   assign slot_exp  = {1'b0, ram_rd.tstamp} + {{(TW+1-srb_pkg::DELAY_W){1'b0}}, delay_ff};
   assign last_exp  = {1'b0, last_ff} + {{(TW+1-srb_pkg::DELAY_W){1'b0}}, delay_ff};
   assign slot_fresh = slot_exp > {1'b0, now_ff};
   assign last_wait  = last_exp > {1'b0, now_ff};

   assign rsp_valid       = vld_ff;
   assign rsp_status      = st_ff;
   assign rsp_handle_out  = ho_ff;
   assign rsp_seq_out     = so_ff;
   assign rsp_gap_skipped = gap_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srb_pkg::S_IDLE:
            if (accept) state_in = req_cmd ? srb_pkg::S_DEQ_CHK : srb_pkg::S_ENQ_CHK;
         srb_pkg::S_ENQ_CHK: state_in = srb_pkg::S_DONE;
         srb_pkg::S_DEQ_CHK:
            if (!full_ff[exp_idx] && !last_wait) state_in = srb_pkg::S_SCAN_CHK;
            else state_in = srb_pkg::S_DONE;
         srb_pkg::S_SCAN_RD: state_in = srb_pkg::S_SCAN_CHK;
         srb_pkg::S_SCAN_CHK:
            if (full_ff[cand_idx] || k_ff == (IW+1)'(srb_pkg::RING_DEPTH - 1) ||
                (cand_ff + 1'b1) > high_ff) state_in = srb_pkg::S_DONE;
            else state_in = srb_pkg::S_SCAN_RD;
         srb_pkg::S_DONE: state_in = srb_pkg::S_IDLE;
         default: state_in = srb_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      full_in = full_ff; exp_in = exp_ff; high_in = high_ff; off_in = off_ff;
      last_in = last_ff; seq_in = seq_ff; k_in = k_ff; cand_in = cand_ff;
      st_in = st_ff; ho_in = ho_ff; so_in = so_ff; gap_in = gap_ff; vld_in = 1'b0;
      ram_we = 1'b0; ram_addr = exp_idx;
      ram_wd.seq = seq_ff; ram_wd.tstamp = now_ff; ram_wd.handle = hin_ff;
      unique case (state_ff)
         srb_pkg::S_IDLE: begin
            ram_addr = req_cmd ? exp_idx : req_seq[IW-1:0];
            if (accept) begin
               st_in = srb_pkg::ST_NOTHING; ho_in = '0; so_in = '0; gap_in = 1'b0;
               if (!req_cmd) begin
                  off_in = req_off; seq_in = req_seq; so_in = req_seq;
               end
            end
         end
         srb_pkg::S_ENQ_CHK: begin
            ram_addr = seq_idx;
            if (seq_ff < exp_ff) st_in = srb_pkg::ST_LATE;
            else if (full_ff[seq_idx] && slot_fresh)
               st_in = (ram_rd.seq == seq_ff) ? srb_pkg::ST_DUP : srb_pkg::ST_BUSY;
            else begin
               st_in = srb_pkg::ST_STORED; ram_we = 1'b1; full_in[seq_idx] = 1'b1;
               if (high_ff < seq_ff) high_in = seq_ff;
            end
         end
         srb_pkg::S_DEQ_CHK: begin
            cand_in = exp_ff + 1'b1; k_in = (IW+1)'(1);
            ram_addr = cand_in[IW-1:0];
            if (full_ff[exp_idx]) begin
               st_in = srb_pkg::ST_DELIVERED; ho_in = srb_pkg::HOUT_W'(ram_rd.handle);
               so_in = ram_rd.seq; exp_in = ram_rd.seq + 1'b1;
               full_in[exp_idx] = 1'b0; last_in = now_ff;
            end
         end
         srb_pkg::S_SCAN_RD: ram_addr = cand_idx;
         srb_pkg::S_SCAN_CHK: begin
            ram_addr = cand_idx;
            if (full_ff[cand_idx]) begin
               st_in = srb_pkg::ST_DELIVERED; ho_in = srb_pkg::HOUT_W'(ram_rd.handle);
               so_in = ram_rd.seq; gap_in = 1'b1; exp_in = ram_rd.seq + 1'b1;
               full_in[cand_idx] = 1'b0; last_in = now_ff;
            end else begin
               cand_in = cand_ff + 1'b1; k_in = k_ff + 1'b1;
            end
         end
         srb_pkg::S_DONE: vld_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srb_pkg::S_IDLE; full_ff <= '0; exp_ff <= '0; high_ff <= '0;
         off_ff <= '0; last_ff <= '0; delay_ff <= srb_pkg::DELAY_RESET; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; full_ff <= full_in; exp_ff <= exp_in; high_ff <= high_in;
         off_ff <= off_in; last_ff <= last_in; vld_ff <= vld_in;
         if (csr_valid && csr_ready) delay_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd; hin_ff <= req_handle_in[srb_pkg::HANDLE_WIDTH-1:0];
         now_ff <= req_now;
      end
      seq_ff <= seq_in; k_ff <= k_in; cand_ff <= cand_in;
      st_ff <= st_in; ho_ff <= ho_in; so_ff <= so_in; gap_ff <= gap_in;
   end

   `SRB_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == srb_pkg::S_DONE, rsp_valid, "no strobe")
   `SRB_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "not busy after accept")
   `SRB_ASSERT_IMPL(a_enq_path, clock, reset, (state_ff == srb_pkg::S_ENQ_CHK) |-> !cmd_ff, "enq path with dequeue")
endmodule
